FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the core rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/core/scpu_pkg.sv
// ----------------------------------------------------------------------------
// scpu_pkg
// types, codes and helpers for the dual-stack instruction core
// ----------------------------------------------------------------------------
package scpu_pkg;

   localparam int unsigned STACK_DEPTH = 32;
   localparam int unsigned PTR_WIDTH   = $clog2(STACK_DEPTH);
   localparam int unsigned WORD_WIDTH  = 16;
   localparam int unsigned PC_WIDTH    = 13;

   typedef logic [PTR_WIDTH-1:0]  ptr_type;
   typedef logic [WORD_WIDTH-1:0] word_type;
   typedef logic [PC_WIDTH-1:0]   pc_type;

   // instruction kind, bits 14..13 when bit 15 is clear
   localparam logic [1:0] KIND_JUMP  = 2'b00;
   localparam logic [1:0] KIND_CJUMP = 2'b01;
   localparam logic [1:0] KIND_CALL  = 2'b10;
   localparam logic [1:0] KIND_ALU   = 2'b11;

   // stack pointer deltas, signed two bits
   localparam logic [1:0] DELTA_NONE = 2'b00;
   localparam logic [1:0] DELTA_PUSH = 2'b01;
   localparam logic [1:0] DELTA_POP2 = 2'b10;
   localparam logic [1:0] DELTA_POP  = 2'b11;

   typedef enum logic [3:0] {
      OP_T      = 4'd0,
      OP_N      = 4'd1,
      OP_ADD    = 4'd2,
      OP_AND    = 4'd3,
      OP_OR     = 4'd4,
      OP_XOR    = 4'd5,
      OP_INV    = 4'd6,
      OP_EQ     = 4'd7,
      OP_LT     = 4'd8,
      OP_SHR    = 4'd9,
      OP_DEC    = 4'd10,
      OP_R      = 4'd11,
      OP_MEM    = 4'd12,
      OP_SHL    = 4'd13,
      OP_DEPTH  = 4'd14,
      OP_ULT    = 4'd15
   } alu_op_type;

   typedef struct packed {
      pc_type   pc;
      word_type t;
      ptr_type  dsp;
      ptr_type  rsp;
   } core_state_type;

   typedef struct packed {
      logic     en;
      ptr_type  ptr;
      word_type data;
   } stack_wr_type;

   // packed so that fetch_address lands in the lowest bits
   typedef struct packed {
      logic     io_read;
      word_type write_data;
      word_type write_address;
      logic     write_enable;
      word_type top_value;
      pc_type   fetch_address;
   } result_type;

   localparam int unsigned RESULT_WIDTH = $bits(result_type);

   // pointer step modulo the stack depth
   function automatic ptr_type move_ptr(ptr_type p, logic [1:0] delta);
      logic [PTR_WIDTH:0] add;
      logic [PTR_WIDTH:0] sum;
      unique case (delta)
         DELTA_NONE: add = '0;
         DELTA_PUSH: add = (PTR_WIDTH+1)'(1);
         DELTA_POP2: add = (PTR_WIDTH+1)'(STACK_DEPTH - 2);
         DELTA_POP:  add = (PTR_WIDTH+1)'(STACK_DEPTH - 1);
         default:    add = '0;
      endcase
      sum = {1'b0, p} + add;
      if (sum >= (PTR_WIDTH+1)'(STACK_DEPTH)) begin
         sum = sum - (PTR_WIDTH+1)'(STACK_DEPTH);
      end
      return sum[PTR_WIDTH-1:0];
   endfunction

   function automatic word_type depth_word(ptr_type rsp, ptr_type dsp);
      return WORD_WIDTH'((32'(rsp) << 8) | 32'(dsp));
   endfunction

endpackage

FILE: rtl/core/stack_cpu_instruction_step.sv
// ----------------------------------------------------------------------------
// stack_cpu_instruction_step
// dual-stack 16-bit core executing one instruction per transaction
// ----------------------------------------------------------------------------
// result path: the request is captured in the input register, then one pass of
//   decode/alu/stack logic feeds the result register
// throughput: one instruction per cycle while rsp_tready stays high; core state
//   and both stacks update in the cycle the instruction moves into the result register
// reset: synchronous, clears pc, t, both pointers, both stacks and handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stack_cpu_instruction_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // reset_req[0], instruction[16:1], read_data[32:17], zero[39:33]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // fetch_address[12:0], top_value[28:13], write_enable[29],
   // write_address[45:30], write_data[61:46], io_read[62], zero[63]
   output logic [63:0] rsp_tdata
);

   logic                     in_valid_ff;
   logic                     in_valid_in;
   logic                     reset_req_ff;
   scpu_pkg::word_type       instruction_ff;
   scpu_pkg::word_type       read_data_ff;
   logic                     out_valid_ff;
   logic                     out_valid_in;
   scpu_pkg::result_type     result_ff;
   scpu_pkg::core_state_type state_ff;
   scpu_pkg::core_state_type state_in;
   scpu_pkg::core_state_type state_next;
   scpu_pkg::result_type     result;
   scpu_pkg::stack_wr_type   dwr;
   scpu_pkg::stack_wr_type   rwr;
   scpu_pkg::stack_wr_type   dwr_gated;
   scpu_pkg::stack_wr_type   rwr_gated;
   scpu_pkg::word_type       n;
   scpu_pkg::word_type       r;
   logic                     advance;
   logic                     req_take;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign state_in     = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         reset_req_ff   <= req_tdata[0];
         instruction_ff <= req_tdata[16:1];
         read_data_ff   <= req_tdata[32:17];
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   always_comb begin
      dwr_gated    = dwr;
      dwr_gated.en = dwr.en && advance;
      rwr_gated    = rwr;
      rwr_gated.en = rwr.en && advance;
   end

   scpu_stack u_dstack (
      .clock   (clock),
      .reset   (reset),
      .rd_ptr  (state_ff.dsp),
      .rd_data (n),
      .wr      (dwr_gated)
   );

   scpu_stack u_rstack (
      .clock   (clock),
      .reset   (reset),
      .rd_ptr  (state_ff.rsp),
      .rd_data (r),
      .wr      (rwr_gated)
   );

   scpu_exec u_exec (
      .reset_req   (reset_req_ff),
      .instruction (instruction_ff),
      .read_data   (read_data_ff),
      .state       (state_ff),
      .n           (n),
      .r           (r),
      .state_next  (state_next),
      .dwr         (dwr),
      .rwr         (rwr),
      .result      (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff};

   `ASSERT_ALWAYS(a_ready_only_when_full, !req_tready |-> in_valid_ff,
      "request side stalled with an empty input register")

   `ASSERT_CLK(a_advance_fills_output, advance |=> rsp_tvalid,
      "executed instruction did not reach the result register")

   `ASSERT_CLK(a_reset_req_clears, advance && reset_req_ff |=>
      (state_ff == '0) && (rsp_tdata[28:0] == '0),
      "reset request did not clear pc and top of stack")

   `ASSERT_CLK(a_no_store_fields_idle, rsp_tvalid && !rsp_tdata[29] |->
      (rsp_tdata[61:30] == '0),
      "store address or data set without a write strobe")

endmodule

FILE: rtl/core/scpu_stack.sv
// ----------------------------------------------------------------------------
// scpu_stack
// stack register file: one read at the current pointer, one write port
// ----------------------------------------------------------------------------
module scpu_stack (
   input  logic                   clock,
   input  logic                   reset,
   input  scpu_pkg::ptr_type      rd_ptr,
   output scpu_pkg::word_type     rd_data,
   input  scpu_pkg::stack_wr_type wr
);

   scpu_pkg::word_type mem_ff [scpu_pkg::STACK_DEPTH];

   assign rd_data = mem_ff[rd_ptr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(scpu_pkg::STACK_DEPTH); i++) begin
            mem_ff[i] <= '0;
         end
      end else if (wr.en) begin
         mem_ff[wr.ptr] <= wr.data;
      end
   end

endmodule

FILE: rtl/core/scpu_exec.sv
// ----------------------------------------------------------------------------
// scpu_exec
// instruction decode, alu and next-state logic for one instruction
// ----------------------------------------------------------------------------
module scpu_exec (
   input  logic                     reset_req,
   input  scpu_pkg::word_type       instruction,
   input  scpu_pkg::word_type       read_data,
   input  scpu_pkg::core_state_type state,
   input  scpu_pkg::word_type       n,
   input  scpu_pkg::word_type       r,
   output scpu_pkg::core_state_type state_next,
   output scpu_pkg::stack_wr_type   dwr,
   output scpu_pkg::stack_wr_type   rwr,
   output scpu_pkg::result_type     result
);

   scpu_pkg::pc_type         pc1;
   scpu_pkg::core_state_type upd;
   scpu_pkg::word_type       alu;
   scpu_pkg::word_type       rdat;
   scpu_pkg::word_type       t;
   scpu_pkg::alu_op_type     op;
   logic                     dw;
   logic                     rw;
   logic                     we;
   logic                     ior;

   assign t   = state.t;
   assign pc1 = state.pc + scpu_pkg::pc_type'(1);
   assign op  = scpu_pkg::alu_op_type'(instruction[11:8]);

   always_comb begin
      unique case (op)
         scpu_pkg::OP_T:     alu = t;
         scpu_pkg::OP_N:     alu = n;
         scpu_pkg::OP_ADD:   alu = t + n;
         scpu_pkg::OP_AND:   alu = t & n;
         scpu_pkg::OP_OR:    alu = t | n;
         scpu_pkg::OP_XOR:   alu = t ^ n;
         scpu_pkg::OP_INV:   alu = ~t;
         scpu_pkg::OP_EQ:    alu = {scpu_pkg::WORD_WIDTH{n == t}};
         scpu_pkg::OP_LT:    alu = {scpu_pkg::WORD_WIDTH{$signed(n) < $signed(t)}};
         scpu_pkg::OP_SHR:   alu = n >> t[3:0];
         scpu_pkg::OP_DEC:   alu = t - scpu_pkg::word_type'(1);
         scpu_pkg::OP_R:     alu = r;
         scpu_pkg::OP_MEM:   alu = read_data;
         scpu_pkg::OP_SHL:   alu = n << t[3:0];
         scpu_pkg::OP_DEPTH: alu = scpu_pkg::depth_word(state.rsp, state.dsp);
         scpu_pkg::OP_ULT:   alu = {scpu_pkg::WORD_WIDTH{n < t}};
         default:            alu = t;
      endcase
   end

   always_comb begin
      upd    = state;
      upd.pc = pc1;
      dw     = 1'b0;
      rw     = 1'b0;
      rdat   = t;
      we     = 1'b0;
      ior    = 1'b0;
      if (instruction[15]) begin
         // literal push
         upd.dsp = scpu_pkg::move_ptr(state.dsp, scpu_pkg::DELTA_PUSH);
         upd.t   = {1'b0, instruction[14:0]};
         dw      = 1'b1;
      end else begin
         unique case (instruction[14:13])
            scpu_pkg::KIND_JUMP: begin
               upd.pc = instruction[12:0];
            end
            scpu_pkg::KIND_CJUMP: begin
               upd.dsp = scpu_pkg::move_ptr(state.dsp, scpu_pkg::DELTA_POP);
               upd.t   = n;
               if (t == '0) begin
                  upd.pc = instruction[12:0];
               end
            end
            scpu_pkg::KIND_CALL: begin
               upd.rsp = scpu_pkg::move_ptr(state.rsp, scpu_pkg::DELTA_PUSH);
               upd.pc  = instruction[12:0];
               rw      = 1'b1;
               rdat    = scpu_pkg::word_type'(pc1);
            end
            scpu_pkg::KIND_ALU: begin
               upd.dsp = scpu_pkg::move_ptr(state.dsp, instruction[1:0]);
               upd.rsp = scpu_pkg::move_ptr(state.rsp, instruction[3:2]);
               upd.t   = alu;
               dw      = instruction[7];
               rw      = instruction[6];
               we      = instruction[5];
               ior     = (op == scpu_pkg::OP_MEM) && (t[15:14] != 2'b00);
               if (instruction[12]) begin
                  upd.pc = r[12:0];
               end
            end
            default: begin
               upd.pc = pc1;
            end
         endcase
      end
   end

   // stacks are cleared only by the module reset, not by reset_req, so their writes go ahead on reset_req
   assign state_next = reset_req ? '0 : upd;

   assign dwr.en   = dw;
   assign dwr.ptr  = upd.dsp;
   assign dwr.data = t;
   assign rwr.en   = rw;
   assign rwr.ptr  = upd.rsp;
   assign rwr.data = rdat;

   assign result.fetch_address = state_next.pc;
   assign result.top_value     = state_next.t;
   assign result.write_enable  = we;
   assign result.write_address = we ? t : '0;
   assign result.write_data    = we ? n : '0;
   assign result.io_read       = ior;

endmodule
